// File: rtl/ffdc_pkg.sv
package ffdc_pkg;

	localparam int unsigned CharW = 8;
	localparam int unsigned MaxRes = 3;

	typedef logic [CharW-1:0] char_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NO_DIR   = 3'd1,
		ST_NO_TYPE  = 3'd2,
		ST_BAD_TYPE = 3'd3,
		ST_TOO_MANY = 3'd4
	} status_t;

	// one input item worth of results: cnt entries, the last one final when fin
	typedef struct packed {
		logic [1:0]                   cnt;
		logic [MaxRes-1:0][CharW-1:0] ch;
		logic                         fin;
		status_t                      st;
	} cmd_t;

	localparam char_t CH_NUL = 8'h00;
	localparam char_t CH_PCT = 8'h25;
	localparam char_t CH_DOT = 8'h2E;
	localparam char_t CH_L   = 8'h4C;

endpackage

// File: rtl/ffdc_in_if.sv
interface ffdc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink (input valid, input char_in, output ready);
endinterface

// File: rtl/ffdc_out_if.sv
interface ffdc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic [2:0] status;
	logic       last;

	modport source (output valid, output out_char, output status, output last, input ready);
	modport sink (input valid, input out_char, input status, input last, output ready);
endinterface

// File: rtl/ffdc_front.sv
module ffdc_front (
	input  logic          clk,
	input  logic          arst_n,
	ffdc_in_if.sink       din,
	output ffdc_pkg::cmd_t cmd,
	output logic          push,
	input  logic          push_ready
);
	import ffdc_pkg::*;

	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_PREFIX_PCT,
		PH_FLAGS,
		PH_WIDTH,
		PH_PREC,
		PH_SUFFIX,
		PH_SUFFIX_PCT,
		PH_DRAIN
	} phase_t;

	typedef struct packed {
		logic [1:0] n;
		char_t      a;
		char_t      b;
		logic       fin;
		status_t    st;
		phase_t     nxt;
	} dres_t;

	function automatic logic is_flag(char_t c);
		return c == 8'h2D || c == 8'h2B || c == 8'h23 || c == 8'h30 ||
			c == 8'h20 || c == 8'h27;
	endfunction

	function automatic logic is_digit(char_t c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_type(char_t c);
		return c == 8'h65 || c == 8'h66 || c == 8'h67 || c == 8'h61 ||
			c == 8'h45 || c == 8'h46 || c == 8'h47 || c == 8'h41;
	endfunction

	function automatic dres_t dir_step(phase_t p, char_t c);
		dres_t r;
		r     = '0;
		r.st  = ST_OK;
		r.nxt = p;
		r.n   = 2'd1;
		priority if (c == CH_NUL) begin
			r.fin = 1'b1;
			r.st  = ST_NO_TYPE;
			r.nxt = PH_PREFIX;
		end else if (is_type(c)) begin
			r.n   = 2'd2;
			r.a   = CH_L;
			r.b   = c;
			r.nxt = PH_SUFFIX;
		end else if (p == PH_FLAGS && is_flag(c)) begin
			r.a = c;
		end else if (is_digit(c)) begin
			r.a = c;
			if (p != PH_PREC) r.nxt = PH_WIDTH;
		end else if (c == CH_DOT && p != PH_PREC) begin
			r.a   = c;
			r.nxt = PH_PREC;
		end else begin
			r.fin = 1'b1;
			r.st  = ST_BAD_TYPE;
			r.nxt = PH_DRAIN;
		end
		return r;
	endfunction

	phase_t phase_q, phase_nxt;
	dres_t  d;
	char_t  c;
	logic   accept;

	assign c        = din.char_in;
	assign din.ready = push_ready;
	assign accept   = din.valid && push_ready;
	assign push     = accept && (cmd.cnt != 2'd0);

	always_comb begin
		cmd       = '0;
		cmd.st    = ST_OK;
		phase_nxt = phase_q;
		d         = dir_step(PH_FLAGS, c);
		unique case (phase_q)
			PH_PREFIX: begin
				if (c == CH_NUL) begin
					cmd.cnt = 2'd1;
					cmd.fin = 1'b1;
					cmd.st  = ST_NO_DIR;
				end else if (c == CH_PCT) begin
					phase_nxt = PH_PREFIX_PCT;
				end else begin
					cmd.cnt   = 2'd1;
					cmd.ch[0] = c;
				end
			end
			PH_PREFIX_PCT: begin
				if (c == CH_PCT) begin
					cmd.cnt   = 2'd2;
					cmd.ch[0] = CH_PCT;
					cmd.ch[1] = CH_PCT;
					phase_nxt = PH_PREFIX;
				end else if (c == CH_NUL) begin
					cmd.cnt   = 2'd1;
					cmd.fin   = 1'b1;
					cmd.st    = ST_NO_TYPE;
					phase_nxt = PH_PREFIX;
				end else begin
					cmd.cnt   = d.n + 2'd1;
					cmd.ch[0] = CH_PCT;
					cmd.ch[1] = d.a;
					cmd.ch[2] = d.b;
					cmd.fin   = d.fin;
					cmd.st    = d.st;
					phase_nxt = d.nxt;
				end
			end
			PH_FLAGS, PH_WIDTH, PH_PREC: begin
				d         = dir_step(phase_q, c);
				cmd.cnt   = d.n;
				cmd.ch[0] = d.a;
				cmd.ch[1] = d.b;
				cmd.fin   = d.fin;
				cmd.st    = d.st;
				phase_nxt = d.nxt;
			end
			PH_SUFFIX: begin
				if (c == CH_NUL) begin
					cmd.cnt   = 2'd1;
					cmd.fin   = 1'b1;
					phase_nxt = PH_PREFIX;
				end else if (c == CH_PCT) begin
					phase_nxt = PH_SUFFIX_PCT;
				end else begin
					cmd.cnt   = 2'd1;
					cmd.ch[0] = c;
				end
			end
			PH_SUFFIX_PCT: begin
				cmd.cnt = (c == CH_PCT) ? 2'd2 : 2'd1;
				if (c == CH_PCT) begin
					cmd.ch[0] = CH_PCT;
					cmd.ch[1] = CH_PCT;
					phase_nxt = PH_SUFFIX;
				end else begin
					cmd.fin   = 1'b1;
					cmd.st    = ST_TOO_MANY;
					phase_nxt = (c == CH_NUL) ? PH_PREFIX : PH_DRAIN;
				end
			end
			PH_DRAIN: begin
				if (c == CH_NUL) phase_nxt = PH_PREFIX;
			end
			default: phase_nxt = PH_PREFIX;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFIX;
		end else if (accept) begin
			phase_q <= phase_nxt;
		end
	end

endmodule

// File: rtl/ffdc_fifo.sv
module ffdc_fifo #(
	parameter int unsigned Depth = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ffdc_pkg::cmd_t wr_data,
	output logic           wr_ready,
	input  logic           pop,
	output ffdc_pkg::cmd_t rd_data,
	output logic           rd_valid
);
	import ffdc_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] Full = CntW'(Depth);

	cmd_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push, do_pop;

	assign wr_ready = count_q != Full;
	assign rd_valid = count_q != '0;
	assign do_push  = push && wr_ready;
	assign do_pop   = pop && rd_valid;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// File: rtl/ffdc_back.sv
module ffdc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  ffdc_pkg::cmd_t cmd,
	input  logic           cmd_valid,
	output logic           pop,
	ffdc_out_if.source     dout
);
	import ffdc_pkg::*;

	logic [1:0] idx_q;
	logic       load, at_end;
	logic       valid_q;
	char_t      char_q;
	status_t    st_q;
	logic       last_q;

	assign load   = cmd_valid && (!valid_q || dout.ready);
	assign at_end = idx_q == (cmd.cnt - 2'd1);
	assign pop    = load && at_end;

	assign dout.valid    = valid_q;
	assign dout.out_char = char_q;
	assign dout.status   = st_q;
	assign dout.last     = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (dout.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= (idx_q < 2'd3) ? cmd.ch[idx_q] : CH_NUL;
			st_q   <= (at_end && cmd.fin) ? cmd.st : ST_OK;
			last_q <= at_end && cmd.fin;
		end
	end

endmodule

// File: rtl/float_format_directive_checker_top.sv
// Path: an item's first result passes through the command queue, then the output register.
// Throughput: one item per cycle while each item yields at most one result and dout.ready
// stays high; an item yielding two or three results holds the output port until all are sent,
// set by the single output register draining the command queue one result per cycle.
// Reset (arst_n low, asynchronous): parse phase back to prefix, queue and output emptied.
module float_format_directive_checker_top #(
	parameter int unsigned QDepth = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	ffdc_in_if.sink     din,
	ffdc_out_if.source  dout
);
	import ffdc_pkg::*;

	cmd_t front_cmd, head_cmd;
	logic push, push_ready, pop, head_valid;

	ffdc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.din        (din),
		.cmd        (front_cmd),
		.push       (push),
		.push_ready (push_ready)
	);

	ffdc_fifo #(.Depth(QDepth)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_data  (front_cmd),
		.wr_ready (push_ready),
		.pop      (pop),
		.rd_data  (head_cmd),
		.rd_valid (head_valid)
	);

	ffdc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head_cmd),
		.cmd_valid (head_valid),
		.pop       (pop),
		.dout      (dout)
	);

endmodule

// File: verif/float_format_directive_checker_top_tb.sv
module float_format_directive_checker_top_tb;
	import ffdc_pkg::*;

	localparam int unsigned CycleLimit = 60000;
	localparam int unsigned HoldCycles = 120;
	localparam int unsigned RandomTotal = 270;

	typedef enum logic [2:0] {
		P_PREFIX,
		P_PREFIX_PCT,
		P_FLAGS,
		P_WIDTH,
		P_PREC,
		P_SUFFIX,
		P_SUFFIX_PCT,
		P_DRAIN
	} fmt_phase_t;

	typedef struct packed {
		char_t   ch;
		status_t st;
		logic    fin;
	} rewritten_t;

	typedef char_t bytes_t[$];

	logic clk;
	logic arst_n;

	ffdc_in_if  din();
	ffdc_out_if dout();

	float_format_directive_checker_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout)
	);

	fmt_phase_t   fmt_phase;
	rewritten_t   rewritten_q[$];
	rewritten_t   head;
	int unsigned  fails;
	int unsigned  chars_sent;
	int unsigned  results_seen;
	int unsigned  endings[5];
	int unsigned  cycles;
	logic         idling;
	int unsigned  hold_reqs;
	int unsigned  hold_seen;
	int unsigned  hold_left;
	string        flag_chars = "-+#0 '";
	string        type_chars = "efgaEFGA";

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------- prediction ----------------

	function automatic void queue_result(char_t c, status_t s, logic f);
		rewritten_q.push_back('{ch: c, st: s, fin: f});
	endfunction

	function automatic void end_with_error(status_t s, char_t c);
		queue_result(CH_NUL, s, 1'b1);
		fmt_phase = (c == CH_NUL) ? P_PREFIX : P_DRAIN;
	endfunction

	function automatic bit is_flag(char_t c);
		return c == "-" || c == "+" || c == "#" || c == "0" || c == " " || c == "'";
	endfunction

	function automatic bit is_type(char_t c);
		return c == "e" || c == "f" || c == "g" || c == "a" ||
			c == "E" || c == "F" || c == "G" || c == "A";
	endfunction

	function automatic void directive_char(char_t c);
		if (c == CH_NUL) begin
			end_with_error(ST_NO_TYPE, c);
		end else if (is_type(c)) begin
			queue_result(CH_L, ST_OK, 1'b0);
			queue_result(c, ST_OK, 1'b0);
			fmt_phase = P_SUFFIX;
		end else if (fmt_phase == P_FLAGS && is_flag(c)) begin
			queue_result(c, ST_OK, 1'b0);
		end else if (c >= "0" && c <= "9") begin
			queue_result(c, ST_OK, 1'b0);
			if (fmt_phase != P_PREC)
				fmt_phase = P_WIDTH;
		end else if (c == CH_DOT && fmt_phase != P_PREC) begin
			queue_result(c, ST_OK, 1'b0);
			fmt_phase = P_PREC;
		end else begin
			end_with_error(ST_BAD_TYPE, c);
		end
	endfunction

	function automatic void rewrite_char(char_t c);
		case (fmt_phase)
			P_PREFIX: begin
				if (c == CH_NUL)
					end_with_error(ST_NO_DIR, c);
				else if (c == CH_PCT)
					fmt_phase = P_PREFIX_PCT;
				else
					queue_result(c, ST_OK, 1'b0);
			end
			P_PREFIX_PCT: begin
				if (c == CH_PCT) begin
					queue_result(CH_PCT, ST_OK, 1'b0);
					queue_result(CH_PCT, ST_OK, 1'b0);
					fmt_phase = P_PREFIX;
				end else if (c == CH_NUL) begin
					end_with_error(ST_NO_TYPE, c);
				end else begin
					queue_result(CH_PCT, ST_OK, 1'b0);
					fmt_phase = P_FLAGS;
					directive_char(c);
				end
			end
			P_FLAGS, P_WIDTH, P_PREC: directive_char(c);
			P_SUFFIX: begin
				if (c == CH_NUL) begin
					queue_result(CH_NUL, ST_OK, 1'b1);
					fmt_phase = P_PREFIX;
				end else if (c == CH_PCT) begin
					fmt_phase = P_SUFFIX_PCT;
				end else begin
					queue_result(c, ST_OK, 1'b0);
				end
			end
			P_SUFFIX_PCT: begin
				if (c == CH_PCT) begin
					queue_result(CH_PCT, ST_OK, 1'b0);
					queue_result(CH_PCT, ST_OK, 1'b0);
					fmt_phase = P_SUFFIX;
				end else begin
					end_with_error(ST_TOO_MANY, c);
				end
			end
			default: begin
				if (c == CH_NUL)
					fmt_phase = P_PREFIX;
			end
		endcase
	endfunction

	// ---------------- monitor and checker ----------------

	always @(posedge clk) begin
		if (arst_n) begin
			if (din.valid && din.ready)
				rewrite_char(din.char_in);
			if (dout.valid && dout.ready) begin
				results_seen++;
				if (rewritten_q.size() == 0) begin
					$error("unexpected result: out_char=%h status=%0d last=%b",
						dout.out_char, dout.status, dout.last);
					fails++;
				end else begin
					head = rewritten_q.pop_front();
					if (dout.out_char !== head.ch) begin
						$error("out_char: expected %h, got %h", head.ch, dout.out_char);
						fails++;
					end
					if (dout.status !== head.st) begin
						$error("status: expected %0d, got %0d", head.st, dout.status);
						fails++;
					end
					if (dout.last !== head.fin) begin
						$error("last: expected %b, got %b", head.fin, dout.last);
						fails++;
					end
					if (head.fin)
						endings[head.st]++;
				end
			end
		end
	end

	// ---------------- receiver ----------------

	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= HoldCycles;
			dout.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			dout.ready <= 1'b0;
		end else begin
			dout.ready <= !idling || ($urandom_range(99) >= 26);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				rewritten_q.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---------------- sender ----------------

	task automatic send_char(input char_t c);
		while (idling && $urandom_range(99) < 26) begin
			din.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		din.valid <= 1'b1;
		din.char_in <= c;
		chars_sent++;
		@(posedge clk);
		while (!din.ready)
			@(posedge clk);
	endtask

	task automatic send_bytes(input bytes_t q);
		foreach (q[i])
			send_char(q[i]);
		send_char(CH_NUL);
	endtask

	task automatic send_str(input string s);
		bytes_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		send_bytes(q);
	endtask

	// ---------------- random format strings ----------------

	function automatic void add_literals(ref bytes_t q);
		char_t c;
		repeat ($urandom_range(0, 3)) begin
			c = char_t'($urandom_range(1, 255));
			q.push_back(c);
			if (c == CH_PCT)
				q.push_back(c);
		end
	endfunction

	function automatic void add_directive(ref bytes_t q, input bit with_type);
		q.push_back(CH_PCT);
		repeat ($urandom_range(0, 3))
			q.push_back(flag_chars[$urandom_range(0, 5)]);
		repeat ($urandom_range(0, 2))
			q.push_back(char_t'("0" + $urandom_range(0, 9)));
		if ($urandom_range(1)) begin
			q.push_back(CH_DOT);
			repeat ($urandom_range(0, 2))
				q.push_back(char_t'("0" + $urandom_range(0, 9)));
		end
		if (with_type)
			q.push_back(type_chars[$urandom_range(0, 7)]);
	endfunction

	function automatic bytes_t random_fmt();
		bytes_t q;
		int unsigned kind;
		kind = $urandom_range(0, 9);
		add_literals(q);
		if (kind < 6) begin
			add_directive(q, 1'b1);
			add_literals(q);
		end else if (kind == 7) begin
			// directive cut short or closed by an arbitrary byte
			add_directive(q, 1'b0);
			if ($urandom_range(1))
				q.push_back(char_t'($urandom_range(1, 255)));
			add_literals(q);
		end else if (kind == 8) begin
			add_directive(q, 1'b1);
			add_literals(q);
			if ($urandom_range(1))
				add_directive(q, 1'b1);
			else
				q.push_back(CH_PCT);
			add_literals(q);
		end else if (kind == 9) begin
			repeat ($urandom_range(1, 8))
				q.push_back($urandom_range(0, 3) == 0 ? CH_PCT : char_t'($urandom_range(1, 255)));
		end
		return q;
	endfunction

	// ---------------- tests ----------------

	task automatic test_directed();
		send_str("");
		send_str("%");
		send_char(8'hFF);
		send_str("%%%-+#0 '7.9E%%");
		send_str("%1");
		send_str("%.xq");
		send_str("%g%");
		send_str("%G%dz");
	endtask

	task automatic test_back_to_back();
		idling <= 1'b0;
		repeat (6)
			send_bytes(random_fmt());
		send_str("%%%%%010.3a%%%%");
		idling <= 1'b1;
	endtask

	task automatic test_backpressure();
		hold_reqs <= hold_reqs + 1;
		idling <= 1'b0;
		send_str("%%%%%-+08.2f%%%%%%");
		send_str("ab%%%e%%cd");
		idling <= 1'b1;
	endtask

	task automatic test_random();
		while (chars_sent < RandomTotal)
			send_bytes(random_fmt());
	endtask

	initial begin
		arst_n = 1'b0;
		din.valid = 1'b0;
		din.char_in = CH_NUL;
		dout.ready = 1'b0;
		idling = 1'b1;
		hold_reqs = 0;
		hold_seen = 0;
		hold_left = 0;
		cycles = 0;
		fails = 0;
		chars_sent = 0;
		results_seen = 0;
		fmt_phase = P_PREFIX;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_back_to_back();
		test_backpressure();
		test_random();
		din.valid <= 1'b0;

		while (rewritten_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("sent %0d format bytes, checked %0d rewritten bytes", chars_sent, results_seen);
		$display("string endings: ok %0d, no directive %0d, missing type %0d, bad type %0d, too many %0d",
			endings[ST_OK], endings[ST_NO_DIR], endings[ST_NO_TYPE], endings[ST_BAD_TYPE],
			endings[ST_TOO_MANY]);
		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
